/* design/record_ring_buffer_drop_oldest_macros.svh */
// Assertion macros for the record trace ring checker.
`ifndef RECORD_RING_BUFFER_DROP_OLDEST_MACROS_SVH
`define RECORD_RING_BUFFER_DROP_OLDEST_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RRB_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RRB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* design/rrb_pkg.sv */
// Package for the record trace ring: widths, sizes and item codes.
package rrb_pkg;
  localparam int BUF_BYTES = 8192;
  localparam int ENTRY_MAX = 256;
  localparam int TAG_MAX   = 31;
  localparam int HEADROOM  = 64;
  localparam int HDR_BYTES = 8;

  localparam logic [2:0] FN_START = 3'd0;
  localparam logic [2:0] FN_TAG   = 3'd1;
  localparam logic [2:0] FN_MSG   = 3'd2;
  localparam logic [2:0] FN_DUMP  = 3'd3;
  localparam logic [2:0] FN_NEXT  = 3'd4;
  localparam logic [2:0] FN_CLEAR = 3'd5;

  localparam logic [0:0] REG_LVL_LIMIT = 1'd0;
endpackage

/* design/rrb_store.sv */
// Byte store: single-port synchronous RAM with registered read data.
module rrb_store #(
  parameter int Depth = rrb_pkg::BUF_BYTES,
  parameter int Aw    = $clog2(Depth)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [Aw-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);
  logic [7:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* design/record_ring_buffer_drop_oldest.sv */
// Top level of the record trace ring: control sequencer around the byte store.
// Records (8-byte little-endian header, tag, message) live in a byte RAM with
// one port and registered read data. Every item is a short sequence on that
// port: clear and unused codes go straight to the result, a tag or message
// byte writes at most once, a dump next reads a byte, a start drops the
// oldest records until the new one fits and writes its header (rejected if
// the ring is empty and it still does not fit), a dump start examines
// records until one passes the level limit, and a dump next that ends a
// record examines the following ones. in_stall is high while an item is in
// work or its result waits on out_stall. BufBytes must be a power of two, as
// pointers wrap by truncation. There is no clearing pass.
module record_ring_buffer_drop_oldest #(
  parameter int BufBytes = rrb_pkg::BUF_BYTES,
  parameter int EntryMax = rrb_pkg::ENTRY_MAX,
  parameter int TagMax   = rrb_pkg::TAG_MAX,
  parameter int Headroom = rrb_pkg::HEADROOM
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_timestamp,
  input  logic [2:0]  in_level,
  input  logic [7:0]  in_tag_length,
  input  logic [15:0] in_msg_length,
  input  logic [7:0]  in_payload_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_out_byte,
  output logic        out_out_valid,
  output logic        out_record_last,
  output logic        out_dump_done,
  output logic        out_accepted,
  output logic [10:0] out_rec_count,
  output logic [13:0] out_fill_bytes,
  output logic [31:0] out_lost_bytes,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int Aw      = $clog2(BufBytes);
  localparam int UsedW   = Aw + 1;
  localparam int MsgCap  = EntryMax - 40;
  localparam int Limit   = BufBytes - Headroom;
  localparam int SzW     = $clog2(EntryMax + 1) + 1;
  localparam int HDR_W   = rrb_pkg::HDR_BYTES;
  localparam logic [1:0] ADDR_LVL = 2'(4 * rrb_pkg::REG_LVL_LIMIT);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HDR   = 4'd1;
  localparam logic [3:0] S_DSC   = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_RDW   = 4'd4;
  localparam logic [3:0] S_RDL5  = 4'd5;
  localparam logic [3:0] S_RDL6  = 4'd6;
  localparam logic [3:0] S_RDL7  = 4'd7;
  localparam logic [3:0] S_EVAL  = 4'd8;
  localparam logic [3:0] S_BYTE  = 4'd9;
  localparam logic [3:0] S_BYTEW = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;
  localparam logic [3:0] S_WR    = 4'd12;

  logic [3:0]        st_r, st_nxt;
  logic [Aw-1:0]     head_r, tail_r, base_r, cur_r;
  logic [10:0]       total_r, left_r;
  logic [UsedW-1:0]  used_r;
  logic [31:0]       drop_r;
  logic [5:0]        otag_r, tfill_r;
  logic [SzW-1:0]    omsg_r, mfill_r;
  logic              open_r;
  logic [SzW-1:0]    off_r, rlen_r;
  logic [2:0]        minlv_r;
  logic              seek_dsc_r;
  logic [2:0]        hidx_r;
  logic [2:0]        lvl_r;
  logic [7:0]        tl_r, ml0_r;
  logic [2:0]        fn_r;
  logic [31:0]       ts_r;
  logic [2:0]        ilv_r;
  logic [5:0]        nt_r;
  logic [SzW-1:0]    nm_r;
  logic [7:0]        pb_r;

  logic              we;
  logic [Aw-1:0]     addr;
  logic [7:0]        wdata, rdata;

  rrb_store #(.Depth(BufBytes), .Aw(Aw)) u_store (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic [SzW-1:0] nsz;
  logic [SzW-1:0] rsz;
  logic [7:0] hbyte;
  assign nsz = SzW'(HDR_W) + SzW'(nt_r) + nm_r;
  assign rsz = SzW'(HDR_W) + SzW'(tl_r) + SzW'({rdata, ml0_r});

  always_comb begin
    unique case (hidx_r)
      3'd0: hbyte = ts_r[7:0];
      3'd1: hbyte = ts_r[15:8];
      3'd2: hbyte = ts_r[23:16];
      3'd3: hbyte = ts_r[31:24];
      3'd4: hbyte = {5'd0, ilv_r};
      3'd5: hbyte = {2'd0, nt_r};
      3'd6: hbyte = 8'(nm_r);
      default: hbyte = 8'(nm_r >> 8);
    endcase
  end

  logic accept_in;
  assign accept_in = in_valid && !in_stall;
  assign in_stall  = (st_r != S_IDLE) || (out_valid && out_stall);
  assign pready    = 1'b1;
  assign prdata    = {29'd0, minlv_r};

  logic fits;
  assign fits = (32'(used_r) + 32'(nsz)) <= 32'(Limit);

  logic [5:0]     tclip;
  logic [SzW-1:0] mclip;
  assign tclip = (in_tag_length > 8'(TagMax)) ? 6'(TagMax) : 6'(in_tag_length);
  assign mclip = (in_msg_length > 16'(MsgCap)) ? SzW'(MsgCap) : SzW'(in_msg_length);

  always_comb begin
    we    = 1'b0;
    addr  = cur_r;
    wdata = pb_r;
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (accept_in) begin
        unique case (in_func)
          rrb_pkg::FN_START: st_nxt = S_DSC;
          rrb_pkg::FN_DUMP:  st_nxt = (total_r != 11'd0) ? S_RD : S_OUT;
          rrb_pkg::FN_NEXT:  st_nxt = (left_r != 11'd0) ? S_BYTE : S_OUT;
          rrb_pkg::FN_TAG, rrb_pkg::FN_MSG: st_nxt = S_WR;
          default:           st_nxt = S_OUT;
        endcase
      end
      S_WR: begin
        if (fn_r == rrb_pkg::FN_TAG) begin
          we = open_r && (tfill_r < otag_r);
          addr = base_r + Aw'(HDR_W) + Aw'(tfill_r);
        end else begin
          we = open_r && (mfill_r < omsg_r);
          addr = base_r + Aw'(HDR_W) + Aw'(otag_r) + Aw'(mfill_r);
        end
        st_nxt = S_OUT;
      end
      S_DSC: begin
        if (fits) st_nxt = S_HDR;
        else if (total_r == 11'd0) st_nxt = S_OUT;
        else st_nxt = S_RD;
        addr = tail_r;
      end
      S_HDR: begin
        we = 1'b1;
        addr = head_r + Aw'(hidx_r);
        wdata = hbyte;
        if (hidx_r == 3'd7) st_nxt = S_OUT;
      end
      S_RD:   begin addr = cur_r + Aw'(4); st_nxt = S_RDW; end
      S_RDW:  begin addr = cur_r + Aw'(5); st_nxt = S_RDL5; end
      S_RDL5: begin addr = cur_r + Aw'(6); st_nxt = S_RDL6; end
      S_RDL6: begin addr = cur_r + Aw'(7); st_nxt = S_RDL7; end
      S_RDL7: begin addr = cur_r + Aw'(7); st_nxt = S_EVAL; end
      S_EVAL: begin
        if (seek_dsc_r) st_nxt = S_DSC;
        else if (lvl_r <= minlv_r) st_nxt = S_OUT;
        else if (left_r != 11'd1) st_nxt = S_RD;
        else st_nxt = S_OUT;
      end
      S_BYTE: begin addr = cur_r + Aw'(off_r); st_nxt = S_BYTEW; end
      S_BYTEW: begin
        if ((off_r + SzW'(1) >= rlen_r) && (left_r != 11'd1)) st_nxt = S_RD;
        else st_nxt = S_OUT;
      end
      S_OUT: if (!(out_valid && out_stall)) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      head_r <= '0; tail_r <= '0; base_r <= '0; cur_r <= '0;
      total_r <= '0; left_r <= '0; used_r <= '0; drop_r <= '0;
      otag_r <= '0; tfill_r <= '0; omsg_r <= '0; mfill_r <= '0; open_r <= 1'b0;
      off_r <= '0; rlen_r <= '0; minlv_r <= 3'd7; hidx_r <= '0;
      out_valid <= 1'b0; seek_dsc_r <= 1'b0;
      out_out_byte <= '0; out_out_valid <= 1'b0; out_record_last <= 1'b0;
      out_accepted <= 1'b0; out_dump_done <= 1'b1;
    end else begin
      st_r <= st_nxt;
      if (psel && penable && pwrite && paddr == ADDR_LVL)
        minlv_r <= pwdata[2:0];
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (st_r)
        S_IDLE: if (accept_in) begin
          fn_r <= in_func; ts_r <= in_timestamp; ilv_r <= in_level;
          nt_r <= tclip; nm_r <= mclip; pb_r <= in_payload_byte;
          out_out_byte <= '0; out_out_valid <= 1'b0; out_record_last <= 1'b0;
          out_accepted <= 1'b0; hidx_r <= '0;
          unique case (in_func)
            rrb_pkg::FN_START: begin left_r <= '0; off_r <= '0; seek_dsc_r <= 1'b1; end
            rrb_pkg::FN_DUMP: begin
              cur_r <= tail_r; left_r <= total_r; seek_dsc_r <= 1'b0;
              if (total_r == 11'd0) off_r <= '0;
            end
            rrb_pkg::FN_CLEAR: begin
              head_r <= '0; tail_r <= '0; total_r <= '0; used_r <= '0;
              open_r <= 1'b0; left_r <= '0; off_r <= '0;
            end
            default: ;
          endcase
        end
        S_WR: if (we) begin
          if (fn_r == rrb_pkg::FN_TAG) tfill_r <= tfill_r + 6'd1;
          else mfill_r <= mfill_r + SzW'(1);
        end
        S_DSC: begin
          cur_r <= tail_r;
          if (!fits) begin
            drop_r <= drop_r + 32'(nsz);
            if (total_r == 11'd0) open_r <= 1'b0;
          end
        end
        S_HDR: begin
          hidx_r <= hidx_r + 3'd1;
          if (hidx_r == 3'd7) begin
            base_r <= head_r; otag_r <= nt_r; omsg_r <= nm_r;
            tfill_r <= '0; mfill_r <= '0; open_r <= 1'b1;
            head_r <= head_r + Aw'(nsz);
            total_r <= total_r + 11'd1;
            used_r <= used_r + UsedW'(nsz);
            out_accepted <= 1'b1;
          end
        end
        S_RDW:  lvl_r <= rdata[2:0];
        S_RDL5: tl_r <= rdata;
        S_RDL6: ml0_r <= rdata;
        S_EVAL: begin
          if (seek_dsc_r) begin
            tail_r <= tail_r + Aw'(rsz);
            total_r <= total_r - 11'd1;
            used_r <= (UsedW'(rsz) > used_r) ? '0 : used_r - UsedW'(rsz);
          end else if (lvl_r <= minlv_r) begin
            rlen_r <= rsz; off_r <= '0;
          end else begin
            cur_r <= cur_r + Aw'(rsz);
            left_r <= left_r - 11'd1;
            off_r <= '0;
          end
        end
        S_BYTEW: begin
          out_out_byte <= rdata; out_out_valid <= 1'b1;
          if (off_r + SzW'(1) >= rlen_r) begin
            out_record_last <= 1'b1;
            cur_r <= cur_r + Aw'(rlen_r);
            left_r <= left_r - 11'd1;
            off_r <= '0;
            seek_dsc_r <= 1'b0;
          end else begin
            off_r <= off_r + SzW'(1);
          end
        end
        S_OUT: if (!(out_valid && out_stall)) begin
          out_valid <= 1'b1;
          out_dump_done <= (left_r == 11'd0);
        end
        default: ;
      endcase
    end
  end

  assign out_rec_count  = total_r;
  assign out_fill_bytes = 14'(used_r);
  assign out_lost_bytes = drop_r;
endmodule

/* design/rrb_checker.sv */
// Port checker for the record trace ring, bound to the top level.
`include "record_ring_buffer_drop_oldest_macros.svh"
module rrb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_out_valid,
  input logic        out_record_last,
  input logic        out_accepted,
  input logic [7:0]  out_out_byte,
  input logic [31:0] out_lost_bytes
);
  `RRB_ASSERT(a_last_valid, out_valid && out_record_last, out_out_valid)
  `RRB_ASSERT(a_byte_zero, out_valid && !out_out_valid, out_out_byte == 8'd0)
  `RRB_ASSERT(a_acc_no_byte, out_valid && out_accepted, !out_out_valid)
  `RRB_ASSERT(a_stall_back, out_valid && out_stall, in_stall)
  `RRB_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_lost_bytes))
endmodule

bind record_ring_buffer_drop_oldest rrb_checker u_rrb_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_out_valid(out_out_valid),
  .out_record_last(out_record_last), .out_accepted(out_accepted),
  .out_out_byte(out_out_byte), .out_lost_bytes(out_lost_bytes)
);
